[hdl/dtse_pkg.sv]
`default_nettype none

package dtse_pkg;

  // field widths
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int DAY_W     = 5;
  localparam int MON_W     = 4;
  localparam int YEAR_W    = 14;
  localparam int SEL_W     = 3;
  localparam int ACT_W     = 2;
  localparam int LD_YEAR_W = 16;

  // width of the wrap remainder unit operands
  localparam int MOD_W = 15;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_YEAR_HIGH = 1'b1;

  localparam logic [YEAR_W-1:0] YEAR_LOW_RST  = 14'd2024;
  localparam logic [YEAR_W-1:0] YEAR_HIGH_RST = 14'd2099;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACCEPT = 2'd2;

  // focus codes
  localparam logic [SEL_W-1:0] SEL_HOUR   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_MINUTE = 3'd1;
  localparam logic [SEL_W-1:0] SEL_DAY    = 3'd2;
  localparam logic [SEL_W-1:0] SEL_MONTH  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_YEAR   = 3'd4;

  typedef struct packed {
    logic                  kind;
    logic signed [7:0]     nav_delta;
    logic signed [7:0]     value_delta;
    logic                  cancel_press;
    logic                  accept_press;
    logic [7:0]            load_hour;
    logic [7:0]            load_minute;
    logic [7:0]            load_day;
    logic [7:0]            load_month;
    logic [LD_YEAR_W-1:0]  load_year;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [HOUR_W-1:0] out_hour;
    logic [MIN_W-1:0]  out_minute;
    logic [DAY_W-1:0]  out_day;
    logic [MON_W-1:0]  out_month;
    logic [YEAR_W-1:0] out_year;
    logic [SEL_W-1:0]  out_selected;
  } out_item_t;

  typedef struct packed {
    logic             capture;
    logic             load;
    logic             sel_step;
    logic             wrap_start;
    logic             wrap_write;
    logic             clamp_year;
    logic             clamp_day;
    logic             out_load;
    logic [ACT_W-1:0] action;
  } dtse_cmd_t;

  typedef struct packed {
    logic kind;
    logic cancel;
    logic accept;
    logic dv_zero;
    logic mod_done;
  } dtse_stat_t;

endpackage

`default_nettype wire

[hdl/dtse_mod_unit.sv]
`default_nettype none

module dtse_mod_unit import dtse_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MOD_W-1:0] dividend,
  input  wire logic [MOD_W-1:0] divisor,
  output logic      [MOD_W-1:0] rem,
  output logic                  done
);

  localparam int CNT_W = $clog2(MOD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MOD_W-1:0] dvd_r, dvd_nxt;
  logic [MOD_W-1:0] div_r, div_nxt;
  logic [MOD_W:0]   partial;
  logic [MOD_W:0]   diff;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    partial  = {rem_r, dvd_r[MOD_W-1]};
    diff     = partial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(MOD_W);
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (partial >= {1'b0, div_r}) ? diff[MOD_W-1:0] : partial[MOD_W-1:0];
      dvd_nxt = {dvd_r[MOD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign rem  = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

[hdl/dtse_datapath.sv]
`default_nettype none

module dtse_datapath import dtse_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [YEAR_W-1:0]    cfg_data,
  input  wire in_item_t             in_data,
  input  wire dtse_cmd_t            cmd,
  output dtse_stat_t                stat,
  output out_item_t                 out_data
);

  localparam logic [7:0]        HOUR_MAX  = 8'd23;
  localparam logic [7:0]        MIN_MAX   = 8'd59;
  localparam logic [7:0]        DAY_CAP   = 8'd31;
  localparam logic [7:0]        MON_MAX   = 8'd12;
  localparam logic [YEAR_W-1:0] INV25     = 14'd7209;  // 25 * 7209 = 1 mod 2^14
  localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;
  localparam logic [9:0]        SEL_BIAS  = 10'd130;   // multiple of 5, keeps sum positive
  localparam logic [16:0]       SEL_RECIP = 17'd205;   // ceil(2^10 / 5)

  function automatic logic leap_of(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] m;
    logic              d4;
    logic              d16;
    logic              d25;
    m   = y * INV25;
    d4  = (y[1:0] == 2'd0);
    d16 = (y[3:0] == 4'd0);
    d25 = (m <= DIV25_MAX);
    return d4 && (!d25 || d16);
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic lp, input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = lp ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [YEAR_W-1:0] clamp_year(input logic [LD_YEAR_W-1:0] y,
                                                   input logic [YEAR_W-1:0] lo,
                                                   input logic [YEAR_W-1:0] hi);
    logic [LD_YEAR_W-1:0] t;
    t = y;
    if (t < LD_YEAR_W'(lo)) t = LD_YEAR_W'(lo);
    if (t > LD_YEAR_W'(hi)) t = LD_YEAR_W'(hi);
    return t[YEAR_W-1:0];
  endfunction

  logic [YEAR_W-1:0] year_lo_r, year_lo_nxt;
  logic [YEAR_W-1:0] year_hi_r, year_hi_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  min_r, min_nxt;
  logic [DAY_W-1:0]  day_r, day_nxt;
  logic [MON_W-1:0]  mon_r, mon_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic              leap_r;
  in_item_t          in_r;
  logic [YEAR_W-1:0] wrap_lo_r;
  logic [YEAR_W-1:0] wrap_hi_r;
  logic [MOD_W-1:0]  wrap_rng_r;
  logic              wrap_neg_r;
  logic              wrap_inv_r;
  out_item_t         out_r;

  logic [DAY_W-1:0]  dim;
  logic [9:0]        sel_sum;
  logic [8:0]        sel_t;
  logic [16:0]       sel_prod;
  logic [6:0]        sel_q;
  logic [8:0]        sel_rem;
  logic [YEAR_W-1:0] fv, flo, fhi;
  logic [16:0]       x;
  logic [16:0]       x_abs;
  logic [MOD_W-1:0]  rng_c;
  logic [MOD_W-1:0]  mod_rem;
  logic              mod_done;
  logic [MOD_W-1:0]  wrap_n;
  logic [MOD_W-1:0]  wrap_sum;
  logic [YEAR_W-1:0] wrap_val;

  assign dim = days_in(leap_r, mon_r);

  // new focus: (sel + nav) mod 5 through a reciprocal multiply
  always_comb begin
    sel_sum  = {7'b0, sel_r} + {{2{in_r.nav_delta[7]}}, in_r.nav_delta} + SEL_BIAS;
    sel_t    = sel_sum[8:0];
    sel_prod = {8'b0, sel_t} * SEL_RECIP;
    sel_q    = sel_prod[16:10];
    sel_rem  = sel_t - ({sel_q, 2'b00} + {2'b00, sel_q});
  end

  // value and range of the focused field
  always_comb begin
    case (sel_r)
      SEL_HOUR: begin
        fv  = YEAR_W'(hour_r);
        flo = '0;
        fhi = YEAR_W'(HOUR_MAX);
      end
      SEL_MINUTE: begin
        fv  = YEAR_W'(min_r);
        flo = '0;
        fhi = YEAR_W'(MIN_MAX);
      end
      SEL_DAY: begin
        fv  = YEAR_W'(day_r);
        flo = YEAR_W'(1);
        fhi = YEAR_W'(dim);
      end
      SEL_MONTH: begin
        fv  = YEAR_W'(mon_r);
        flo = YEAR_W'(1);
        fhi = YEAR_W'(MON_MAX);
      end
      default: begin
        fv  = year_r;
        flo = year_lo_r;
        fhi = year_hi_r;
      end
    endcase
    x     = {3'b000, fv} - {3'b000, flo}
            + {{9{in_r.value_delta[7]}}, in_r.value_delta};
    x_abs = x[16] ? (~x + 17'd1) : x;
    rng_c = {1'b0, fhi} - {1'b0, flo} + MOD_W'(1);
  end

  dtse_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.wrap_start),
    .dividend (x_abs[MOD_W-1:0]),
    .divisor  (rng_c),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  // fold a negative remainder back into range and add the low bound; an inverted range gives the high bound
  always_comb begin
    wrap_n   = (wrap_neg_r && (mod_rem != '0)) ? (wrap_rng_r - mod_rem) : mod_rem;
    wrap_sum = {1'b0, wrap_lo_r} + wrap_n;
    wrap_val = wrap_inv_r ? wrap_hi_r : wrap_sum[YEAR_W-1:0];
  end

  always_comb begin
    year_lo_nxt = year_lo_r;
    year_hi_nxt = year_hi_r;
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    day_nxt     = day_r;
    mon_nxt     = mon_r;
    year_nxt    = year_r;
    sel_nxt     = sel_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_YEAR_LOW:  year_lo_nxt = cfg_data;
        CFG_YEAR_HIGH: year_hi_nxt = cfg_data;
        default: ;
      endcase
    end
    if (cmd.load) begin
      hour_nxt = (in_r.load_hour > HOUR_MAX) ? HOUR_MAX[HOUR_W-1:0]
                                              : in_r.load_hour[HOUR_W-1:0];
      min_nxt  = (in_r.load_minute > MIN_MAX) ? MIN_MAX[MIN_W-1:0]
                                               : in_r.load_minute[MIN_W-1:0];
      // days above 31 end up at the month length anyway
      day_nxt  = (in_r.load_day > DAY_CAP) ? DAY_CAP[DAY_W-1:0]
                                            : in_r.load_day[DAY_W-1:0];
      if (in_r.load_month == 8'd0) begin
        mon_nxt = MON_W'(1);
      end else if (in_r.load_month > MON_MAX) begin
        mon_nxt = MON_MAX[MON_W-1:0];
      end else begin
        mon_nxt = in_r.load_month[MON_W-1:0];
      end
      year_nxt = clamp_year(in_r.load_year, year_lo_r, year_hi_r);
      sel_nxt  = SEL_HOUR;
    end
    if (cmd.sel_step) begin
      sel_nxt = sel_rem[SEL_W-1:0];
    end
    if (cmd.wrap_write) begin
      case (sel_r)
        SEL_HOUR:   hour_nxt = wrap_val[HOUR_W-1:0];
        SEL_MINUTE: min_nxt  = wrap_val[MIN_W-1:0];
        SEL_DAY:    day_nxt  = wrap_val[DAY_W-1:0];
        SEL_MONTH:  mon_nxt  = wrap_val[MON_W-1:0];
        default:    year_nxt = wrap_val;
      endcase
    end
    if (cmd.clamp_year) begin
      year_nxt = clamp_year(LD_YEAR_W'(year_r), year_lo_r, year_hi_r);
    end
    if (cmd.clamp_day) begin
      if (day_r == '0) begin
        day_nxt = DAY_W'(1);
      end else if (day_r > dim) begin
        day_nxt = dim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_lo_r <= YEAR_LOW_RST;
      year_hi_r <= YEAR_HIGH_RST;
      hour_r    <= '0;
      min_r     <= '0;
      day_r     <= DAY_W'(1);
      mon_r     <= MON_W'(1);
      year_r    <= YEAR_LOW_RST;
      sel_r     <= SEL_HOUR;
    end else begin
      year_lo_r <= year_lo_nxt;
      year_hi_r <= year_hi_nxt;
      hour_r    <= hour_nxt;
      min_r     <= min_nxt;
      day_r     <= day_nxt;
      mon_r     <= mon_nxt;
      year_r    <= year_nxt;
      sel_r     <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    leap_r <= leap_of(year_r);
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.wrap_start) begin
      wrap_lo_r  <= flo;
      wrap_hi_r  <= fhi;
      wrap_rng_r <= rng_c;
      wrap_neg_r <= x[16];
      wrap_inv_r <= (fhi < flo);
    end
    if (cmd.out_load) begin
      out_r.action       <= cmd.action;
      out_r.out_hour     <= hour_r;
      out_r.out_minute   <= min_r;
      out_r.out_day      <= day_r;
      out_r.out_month    <= mon_r;
      out_r.out_year     <= year_r;
      out_r.out_selected <= sel_r;
    end
  end

  always_comb begin
    stat.kind     = in_r.kind;
    stat.cancel   = in_r.cancel_press;
    stat.accept   = in_r.accept_press;
    stat.dv_zero  = (in_r.value_delta == 8'sd0);
    stat.mod_done = mod_done;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[hdl/dtse_ctrl.sv]
`default_nettype none

module dtse_ctrl import dtse_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dtse_stat_t stat,
  output dtse_cmd_t       cmd
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_DECODE = 4'd1;
  localparam logic [ST_W-1:0] S_WSETUP = 4'd2;
  localparam logic [ST_W-1:0] S_WRUN   = 4'd3;
  localparam logic [ST_W-1:0] S_WDONE  = 4'd4;
  localparam logic [ST_W-1:0] S_CLAMPY = 4'd5;
  localparam logic [ST_W-1:0] S_LEAPW  = 4'd6;
  localparam logic [ST_W-1:0] S_DAYCL  = 4'd7;
  localparam logic [ST_W-1:0] S_OUT    = 4'd8;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.action    = act_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.kind) begin
          cmd.load  = 1'b1;
          act_nxt   = ACT_NONE;
          state_nxt = S_LEAPW;
        end else if (stat.cancel) begin
          act_nxt   = ACT_CANCEL;
          state_nxt = S_OUT;
        end else if (stat.accept) begin
          act_nxt   = ACT_ACCEPT;
          state_nxt = S_CLAMPY;
        end else begin
          cmd.sel_step = 1'b1;
          act_nxt      = ACT_NONE;
          state_nxt    = stat.dv_zero ? S_OUT : S_WSETUP;
        end
      end
      S_WSETUP: begin
        cmd.wrap_start = 1'b1;
        state_nxt      = S_WRUN;
      end
      S_WRUN: begin
        if (stat.mod_done) begin
          state_nxt = S_WDONE;
        end
      end
      S_WDONE: begin
        cmd.wrap_write = 1'b1;
        state_nxt      = S_CLAMPY;
      end
      S_CLAMPY: begin
        cmd.clamp_year = 1'b1;
        state_nxt      = S_LEAPW;
      end
      S_LEAPW: begin
        state_nxt = S_DAYCL;
      end
      S_DAYCL: begin
        cmd.clamp_day = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= ACT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[hdl/date_time_set_encoder_control.sv]
// result path: cancel or a focus-only beat goes from decode to the output register;
//   load runs the leap wait and day clamp, accept also the year clamp first, and a
//   wrap runs the remainder unit before those; one beat is handled at a time
// the wrap uses the 15-step restoring remainder unit, one offset bit per cycle
// reset: synchronous, active low; clears control, editor fields and year bounds
`default_nettype none

module date_time_set_encoder_control import dtse_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes: the user writes only while idle; the block does not enforce it
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [YEAR_W-1:0]    cfg_data,
  // input beats
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  // result beats
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  // command and status between sequencer and datapath
  dtse_cmd_t  cmd;
  dtse_stat_t stat;

  // sequencer: decode the beat, run the wrap, the clamp steps, then the
  // output register; a new beat is taken while a result still waits
  dtse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: edited fields, year bounds, input holding register, focus
  // rotation, remainder unit for the wrap, leap/month length, result register
  dtse_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/dtse_checker.sv]
`default_nettype none

module dtse_checker import dtse_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one beat in flight at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_hour <= 5'd23 && out_data.out_minute <= 6'd59
                  && out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12
                  && out_data.out_day >= 5'd1 && out_data.out_selected <= SEL_YEAR
                  && (out_data.action == ACT_NONE || out_data.action == ACT_CANCEL
                      || out_data.action == ACT_ACCEPT))
    else $error("result field out of range");

  // day never passes the month length (February taken as 29)
  a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.out_month == 4'd2 && out_data.out_day > 5'd29)
                  && !((out_data.out_month == 4'd4 || out_data.out_month == 4'd6
                        || out_data.out_month == 4'd9 || out_data.out_month == 4'd11)
                       && out_data.out_day > 5'd30))
    else $error("day beyond month length");

endmodule

bind date_time_set_encoder_control dtse_checker u_dtse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
